[rtl/core/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Clocked assertion that also holds during reset.
`define ASSERT_CLK_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

[rtl/core/b64c_pkg.sv]
`timescale 1ns / 1ps

package b64c_pkg;

  // Direction register codes.
  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  localparam logic [7:0] PAD_CHAR = 8'h3d;

  // Codec state carried from item to item.
  typedef struct packed {
    logic [23:0] group_bits;
    logic [1:0]  group_count;
    logic        decode_stopped;
  } b64c_state_t;

  // All beats produced by one input item.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [2:0]      count;
    logic            has_data;
    logic            msg_end;
  } b64c_group_t;

  // Six-bit value to alphabet character.
  function automatic logic [7:0] enc_char(input logic [5:0] v);
    logic [7:0] w;
    begin
      w = {2'b00, v};
      if (v < 6'd26) begin
        enc_char = 8'h41 + w;
      end else if (v < 6'd52) begin
        enc_char = 8'h61 + (w - 8'd26);
      end else if (v < 6'd62) begin
        enc_char = 8'h30 + (w - 8'd52);
      end else if (v == 6'd62) begin
        enc_char = 8'h2b;
      end else begin
        enc_char = 8'h2f;
      end
    end
  endfunction

  // Character to {valid, six-bit value}; valid is low outside the alphabet.
  function automatic logic [6:0] dec_char(input logic [7:0] c);
    logic [7:0] t;
    begin
      t = 8'h00;
      dec_char = 7'h00;
      if (c >= 8'h41 && c <= 8'h5a) begin
        t = c - 8'h41;
        dec_char = {1'b1, t[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7a) begin
        t = c - 8'h61 + 8'd26;
        dec_char = {1'b1, t[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
        t = c - 8'h30 + 8'd52;
        dec_char = {1'b1, t[5:0]};
      end else if (c == 8'h2b) begin
        dec_char = {1'b1, 6'd62};
      end else if (c == 8'h2f) begin
        dec_char = {1'b1, 6'd63};
      end
    end
  endfunction

endpackage

[rtl/core/b64c_step.sv]
`timescale 1ns / 1ps

// Combinational step: folds one item into the codec state and forms its beats.
module b64c_step (
  input  logic                 direction,
  input  b64c_pkg::b64c_state_t cur,
  input  logic [7:0]           in_byte,
  input  logic                 in_present,
  input  logic                 in_last,
  output b64c_pkg::b64c_state_t nxt,
  output b64c_pkg::b64c_group_t res
);
  import b64c_pkg::*;

  logic [23:0] bits1;
  logic [23:0] tail;
  logic [2:0]  cnt1;
  logic        stop;
  logic [6:0]  dv;

  always_comb begin
    res   = '0;
    nxt   = cur;
    bits1 = cur.group_bits;
    cnt1  = {1'b0, cur.group_count};
    stop  = cur.decode_stopped;
    tail  = '0;
    dv    = dec_char(in_byte);

    if (direction == DIR_ENCODE) begin
      // Gather bytes; a full group gives four characters.
      if (in_present) begin
        bits1 = {cur.group_bits[15:0], in_byte};
        cnt1  = cnt1 + 3'd1;
      end
      if (cnt1 == 3'd3) begin
        res.bytes[0] = enc_char(bits1[23:18]);
        res.bytes[1] = enc_char(bits1[17:12]);
        res.bytes[2] = enc_char(bits1[11:6]);
        res.bytes[3] = enc_char(bits1[5:0]);
        res.count    = 3'd4;
        bits1        = '0;
        cnt1         = '0;
      end else if (in_last && cnt1 != 3'd0) begin
        // Partial group at the end of the message: pad with '='.
        tail = (cnt1 == 3'd1) ? {bits1[7:0], 16'h0000} : {bits1[15:0], 8'h00};
        res.bytes[0] = enc_char(tail[23:18]);
        res.bytes[1] = enc_char(tail[17:12]);
        res.bytes[2] = (cnt1 == 3'd2) ? enc_char(tail[11:6]) : PAD_CHAR;
        res.bytes[3] = PAD_CHAR;
        res.count    = 3'd4;
      end
    end else begin
      // Gather characters until a pad or a bad character stops decoding.
      if (in_present && !cur.decode_stopped) begin
        if (!dv[6]) begin
          stop = 1'b1;
        end else begin
          bits1 = {cur.group_bits[17:0], dv[5:0]};
          cnt1  = {1'b0, cur.group_count + 2'd1};
          if (cnt1 == 3'd0) begin
            res.bytes[0] = bits1[23:16];
            res.bytes[1] = bits1[15:8];
            res.bytes[2] = bits1[7:0];
            res.count    = 3'd3;
            bits1        = '0;
          end
        end
      end
      // Leftover characters at the end give one or two bytes.
      if (in_last && cnt1 == 3'd2) begin
        res.bytes[0] = bits1[11:4];
        res.count    = 3'd1;
      end else if (in_last && cnt1 == 3'd3) begin
        res.bytes[0] = bits1[17:10];
        res.bytes[1] = bits1[9:2];
        res.count    = 3'd2;
      end
    end

    nxt.group_bits     = bits1;
    nxt.group_count    = cnt1[1:0];
    nxt.decode_stopped = stop;
    res.has_data       = 1'b1;

    // The end of a message closes the run; an empty one gives a bare marker.
    if (in_last) begin
      if (res.count == 3'd0) begin
        res.count    = 3'd1;
        res.has_data = 1'b0;
      end
      res.msg_end = 1'b1;
      nxt         = '0;
    end
  end

endmodule

[rtl/core/base64_codec_unit.sv]
`timescale 1ns / 1ps

// Channel   Dir  Beat contents
// s_axis    in   tdata: data_byte; tuser: byte_present; tlast: last_item
// m_axis    out  tdata: out_byte; tuser: byte_valid, run_last; tlast: message_end
// cfg       in   cfg_we, cfg_wdata: direction (write clears the partial group)
//
// An input beat passes the input register, then the beat group register, before
// its first output beat. The serializer sends an item's beats one at a time
// (four for a full encoded group), while the input register takes the next item.
// Reset clears the state, the input register and the beat group register.
// Output stalls back up through the group register into the input register.
module base64_codec_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] byte_present
  input  logic       s_axis_tlast,
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [1:0] m_axis_tuser,   // [0] byte_valid, [1] run_last
  output logic       m_axis_tlast
);
  import b64c_pkg::*;

  logic        direction;
  b64c_state_t state;
  b64c_state_t state_next;
  b64c_group_t step_res;
  b64c_group_t grp;
  logic        grp_valid;
  logic [1:0]  idx;
  logic        in_valid;
  logic [7:0]  in_byte;
  logic        in_present;
  logic        in_last;
  logic        last_beat;
  logic        out_fire;
  logic        grp_free;
  logic        proc;
  logic        in_fire;

  b64c_step u_step (
    .direction (direction),
    .cur       (state),
    .in_byte   (in_byte),
    .in_present(in_present),
    .in_last   (in_last),
    .nxt       (state_next),
    .res       (step_res)
  );

  // Handshake control.
  assign last_beat     = (({1'b0, idx} + 3'd1) == grp.count);
  assign out_fire      = m_axis_tvalid && m_axis_tready;
  assign grp_free      = !grp_valid || (out_fire && last_beat);
  assign proc          = in_valid && grp_free;
  assign s_axis_tready = !in_valid || proc;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // Output beat from the group register.
  assign m_axis_tvalid = grp_valid;
  assign m_axis_tdata  = grp.bytes[idx];
  assign m_axis_tuser  = {last_beat, grp.has_data};
  assign m_axis_tlast  = grp.msg_end && last_beat;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_fire) begin
      in_valid <= 1'b1;
    end else if (proc) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_byte    <= s_axis_tdata;
      in_present <= s_axis_tuser;
      in_last    <= s_axis_tlast;
    end
  end

  // Direction register and codec state; a configuration write aborts the message.
  always_ff @(posedge clk) begin
    if (rst) begin
      direction <= DIR_ENCODE;
      state     <= '0;
    end else if (cfg_we) begin
      direction <= cfg_wdata;
      state     <= '0;
    end else if (proc) begin
      state <= state_next;
    end
  end

  // Beat group register and serializer index.
  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      idx       <= '0;
    end else if (proc) begin
      grp_valid <= (step_res.count != 3'd0);
      idx       <= '0;
    end else if (out_fire) begin
      if (last_beat) begin
        grp_valid <= 1'b0;
        idx       <= '0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (proc) begin
      grp <= step_res;
    end
  end

endmodule

[rtl/core/b64c_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Port-level checks on the codec output stream.
module b64c_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [1:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  logic [10:0] out_beat;
  logic        is_marker;

  // Everything a beat carries, and the bare end marker case.
  assign out_beat  = {m_axis_tlast, m_axis_tuser, m_axis_tdata};
  assign is_marker = m_axis_tvalid && !m_axis_tuser[0];

  // A stalled output beat holds its contents.
  `ASSERT_CLK(a_hold, clk, rst, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(out_beat))

  // The end of a message is always the last beat of its item.
  `ASSERT_CLK(a_end_run, clk, rst, m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1])

  // A bare marker is a zero byte that closes the message.
  `ASSERT_CLK(a_marker, clk, rst, is_marker |-> m_axis_tlast && m_axis_tuser[1] && m_axis_tdata == 8'h00)

  // No output beat right after reset.
  `ASSERT_CLK_ALWAYS(a_rst_idle, clk, rst |=> !m_axis_tvalid)

endmodule

bind base64_codec_unit b64c_checker u_b64c_checker (
  .clk          (clk),
  .rst          (rst),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser),
  .m_axis_tlast (m_axis_tlast)
);
